// ----- sv/ppe_pkg.sv -----
// Shared types and constants of the piecewise polynomial evaluator.
// Holds action, status and register codes and the multiply-add control struct.
// No dependencies.
package ppe_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int MAX_ORDER_DEF    = 9;

    localparam int DATA_W   = 32;
    localparam int SLOT_W   = 7;
    localparam int CSLOT_W  = 4;
    localparam int SEG_W    = 7;
    localparam int SEGOUT_W = 6;
    localparam int ORDER_W  = 4;
    localparam int CFG_W    = 7;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ACT_KNOT = 2'd0,
        ACT_COEF = 2'd1,
        ACT_EVAL = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_DISORDER  = 2'd1,
        STS_SATURATED = 2'd2
    } status_t;

    typedef enum logic {
        REG_SEGMENTS = 1'b0,
        REG_ORDER    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic clr;
        logic sub;
        logic load;
        logic mul;
        logic add;
    } mac_ctl_t;

endpackage

// ----- sv/ppe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ppe_mac.sv -----
// Shared arithmetic unit: offset subtract, 32x32 multiply, rounding add, saturation.
// Depends on ppe_pkg.
module ppe_mac import ppe_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctl_t                 ctl,
    input  logic signed [DATA_W-1:0] x,
    input  logic signed [DATA_W-1:0] knot,
    input  logic signed [DATA_W-1:0] coef,
    output logic signed [DATA_W-1:0] acc,
    output logic                     sat
);

    logic signed [DATA_W:0]     diff;
    logic                       diff_ovf;
    logic signed [DATA_W-1:0]   t_sat;
    logic signed [DATA_W-1:0]   t_reg;
    logic signed [DATA_W-1:0]   acc_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [2*DATA_W-1:0] prod_rnd;
    logic signed [47:0]         rnd;
    logic signed [48:0]         sum;
    logic                       sum_ovf;
    logic signed [DATA_W-1:0]   sum_sat;
    logic                       sat_reg;

    always_comb
    begin
        diff     = $signed({x[DATA_W-1], x}) - $signed({knot[DATA_W-1], knot});
        diff_ovf = diff[DATA_W] != diff[DATA_W-1];
        if (diff_ovf)
        begin
            t_sat = diff[DATA_W] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            t_sat = diff[DATA_W-1:0];
        end

        prod_rnd = prod_reg + 64'sd32768;
        rnd      = prod_rnd[63:16];
        sum      = $signed({rnd[47], rnd}) + $signed({{17{coef[DATA_W-1]}}, coef});
        sum_ovf  = !((&sum[48:31]) || !(|sum[48:31]));
        if (sum_ovf)
        begin
            sum_sat = sum[48] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            sum_sat = sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
        end
        else if (ctl.clr)
        begin
            sat_reg <= 1'b0;
        end
        else if ((ctl.sub && diff_ovf) || (ctl.add && sum_ovf))
        begin
            sat_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sub)
        begin
            t_reg <= t_sat;
        end
        if (ctl.load)
        begin
            acc_reg <= coef;
        end
        else if (ctl.add)
        begin
            acc_reg <= sum_sat;
        end
        if (ctl.mul)
        begin
            prod_reg <= acc_reg * t_reg;
        end
    end

    assign acc = acc_reg;
    assign sat = sat_reg;

endmodule

// ----- sv/piecewise_polynomial_evaluator.sv -----
// Piecewise polynomial evaluator, Q16.16, one shared multiply-add unit under a sequencer.
// Depends on ppe_pkg, ppe_ram, ppe_mac.
//
//  channel   signals                              dir   beat
//  s_*       s_tvalid s_tready s_tdata s_tuser    in    write knot, write coef or evaluate
//  m_*       m_tvalid m_tready m_tdata m_tuser    out   one per evaluate
//  cfg_*     cfg_wr_en cfg_addr cfg_wdata         in    register write, no wait
//
// Write beats are taken in IDLE. An evaluate is accepted in IDLE, then either binary-searches
// on restart (at most ceil(log2 M) probes, each SRCH then SCMP) or advances segment by segment
// (ADV then ACMP) from the current one, then runs KNOT, SUB, LOAD, a MUL/ADD pair per
// polynomial order step, and DONE, using the multiply-add loop and the single knot read port.
// Reset clears the sequencer, current segment and previous sample; tables hold
// garbage until written. A stalled result holds in the output register while the
// next beat is taken; a finished evaluate waits for that register to drain.
module piecewise_polynomial_evaluator import ppe_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int MAX_ORDER    = MAX_ORDER_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // slot_index, coef_slot, write_value, sample_x, restart, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // poly_value, segment_used, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [1:0]            m_tuser,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int STRIDE     = MAX_ORDER + 1;
    localparam int KNOT_DEPTH = MAX_SEGMENTS + 1;
    localparam int COEF_DEPTH = MAX_SEGMENTS * STRIDE;
    localparam int KW         = $clog2(KNOT_DEPTH);
    localparam int CW         = $clog2(COEF_DEPTH);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_SRCH = 11'b000_0000_0010,
        ST_SCMP = 11'b000_0000_0100,
        ST_ADV  = 11'b000_0000_1000,
        ST_ACMP = 11'b000_0001_0000,
        ST_KNOT = 11'b000_0010_0000,
        ST_SUB  = 11'b000_0100_0000,
        ST_LOAD = 11'b000_1000_0000,
        ST_MUL  = 11'b001_0000_0000,
        ST_ADD  = 11'b010_0000_0000,
        ST_DONE = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0]        in_slot;
    logic [CSLOT_W-1:0]       in_cslot;
    logic signed [DATA_W-1:0] in_wval;
    logic signed [DATA_W-1:0] in_x;
    logic                     in_restart;
    logic                     accept;

    logic [SEG_W-1:0]   segs_reg;
    logic [ORDER_W-1:0] order_reg;
    logic [SEG_W-1:0]   cfg_segs;
    logic [ORDER_W-1:0] cfg_order;

    logic [SEG_W-1:0]         seg_reg, seg_next;
    logic [SEG_W-1:0]         lo_reg, lo_next;
    logic [SEG_W-1:0]         hi_reg, hi_next;
    logic [SEG_W-1:0]         mid_reg, mid_next;
    logic [SEG_W:0]           mid_sum;
    logic [SEG_W-1:0]         cur_seg_reg;
    logic signed [DATA_W-1:0] prev_reg;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic                     disorder_reg, disorder_next;
    logic [ORDER_W-1:0]       k_reg, k_next;
    logic [CW-1:0]            caddr_reg, caddr_next;
    logic                     out_load;

    logic                     knot_we;
    logic [KW-1:0]            knot_raddr;
    logic signed [DATA_W-1:0] knot_rdata;
    logic                     coef_we;
    logic [CW-1:0]            coef_waddr;
    logic signed [DATA_W-1:0] coef_rdata;

    mac_ctl_t                 mac_ctl;
    logic signed [DATA_W-1:0] mac_acc;
    logic                     mac_sat;

    logic                     m_tvalid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic [SEGOUT_W-1:0]      out_seg_reg;
    status_t                  out_status_reg;

    assign in_slot    = s_tdata[6:0];
    assign in_cslot   = s_tdata[10:7];
    assign in_wval    = s_tdata[42:11];
    assign in_x       = s_tdata[74:43];
    assign in_restart = s_tdata[75];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign knot_we    = accept && (action_t'(s_tuser) == ACT_KNOT)
                        && (32'(in_slot) <= MAX_SEGMENTS);
    assign coef_we    = accept && (action_t'(s_tuser) == ACT_COEF)
                        && (32'(in_slot) < MAX_SEGMENTS) && (32'(in_cslot) <= MAX_ORDER);
    assign coef_waddr = CW'(32'(in_slot) * STRIDE + 32'(in_cslot));

    ppe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (KNOT_DEPTH)
    ) u_knot_ram (
        .clk   (clk),
        .we    (knot_we),
        .waddr (KW'(in_slot)),
        .wdata (in_wval),
        .raddr (knot_raddr),
        .rdata (knot_rdata)
    );

    ppe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (in_wval),
        .raddr (caddr_reg),
        .rdata (coef_rdata)
    );

    ppe_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .x     (x_reg),
        .knot  (knot_rdata),
        .coef  (coef_rdata),
        .acc   (mac_acc),
        .sat   (mac_sat)
    );

    // Register write clamping
    always_comb
    begin
        cfg_segs = cfg_wdata[SEG_W-1:0];
        if (cfg_segs == '0)
        begin
            cfg_segs = SEG_W'(1);
        end
        else if (32'(cfg_segs) > MAX_SEGMENTS)
        begin
            cfg_segs = SEG_W'(MAX_SEGMENTS);
        end
        cfg_order = cfg_wdata[ORDER_W-1:0];
        if (32'(cfg_order) > MAX_ORDER)
        begin
            cfg_order = ORDER_W'(MAX_ORDER);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segs_reg  <= SEG_W'(1);
            order_reg <= ORDER_W'(3);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_SEGMENTS: segs_reg  <= cfg_segs;
                REG_ORDER:    order_reg <= cfg_order;
                default:      segs_reg  <= segs_reg;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        seg_next      = seg_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        x_next        = x_reg;
        disorder_next = disorder_reg;
        k_next        = k_reg;
        caddr_next    = caddr_reg;
        mac_ctl       = '0;
        out_load      = 1'b0;
        knot_raddr    = KW'(seg_reg);
        mid_sum       = {1'b0, lo_reg} + {1'b0, hi_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action_t'(s_tuser) == ACT_EVAL))
                begin
                    x_next      = in_x;
                    mac_ctl.clr = 1'b1;
                    if (in_restart)
                    begin
                        lo_next       = '0;
                        hi_next       = segs_reg;
                        disorder_next = 1'b0;
                        state_next    = ST_SRCH;
                    end
                    else
                    begin
                        disorder_next = in_x < prev_reg;
                        seg_next      = (cur_seg_reg >= segs_reg) ? segs_reg - 1'b1
                                                                 : cur_seg_reg;
                        state_next    = ST_ADV;
                    end
                end
            end
            ST_SRCH:
            begin
                if ((SEG_W+1)'(lo_reg) + 1'b1 < (SEG_W+1)'(hi_reg))
                begin
                    mid_next   = mid_sum[SEG_W:1];
                    knot_raddr = KW'(mid_sum[SEG_W:1]);
                    state_next = ST_SCMP;
                end
                else
                begin
                    seg_next   = lo_reg;
                    state_next = ST_KNOT;
                end
            end
            ST_SCMP:
            begin
                if (knot_rdata > x_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg;
                end
                state_next = ST_SRCH;
            end
            ST_ADV:
            begin
                knot_raddr = KW'(seg_reg + 1'b1);
                if ((SEG_W+1)'(seg_reg) + 1'b1 < (SEG_W+1)'(segs_reg))
                begin
                    state_next = ST_ACMP;
                end
                else
                begin
                    state_next = ST_KNOT;
                end
            end
            ST_ACMP:
            begin
                if (x_reg > knot_rdata)
                begin
                    seg_next   = seg_reg + 1'b1;
                    state_next = ST_ADV;
                end
                else
                begin
                    state_next = ST_KNOT;
                end
            end
            ST_KNOT:
            begin
                caddr_next = CW'(32'(seg_reg) * STRIDE);
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                mac_ctl.sub = 1'b1;
                state_next  = ST_LOAD;
            end
            ST_LOAD:
            begin
                mac_ctl.load = 1'b1;
                k_next       = ORDER_W'(1);
                if (order_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    caddr_next = caddr_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                mac_ctl.mul = 1'b1;
                state_next  = ST_ADD;
            end
            ST_ADD:
            begin
                mac_ctl.add = 1'b1;
                if (k_reg == order_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    caddr_next = caddr_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cur_seg_reg  <= '0;
            prev_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                cur_seg_reg  <= seg_reg;
                prev_reg     <= x_reg;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg      <= seg_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        x_reg        <= x_next;
        disorder_reg <= disorder_next;
        k_reg        <= k_next;
        caddr_reg    <= caddr_next;
        if (out_load)
        begin
            out_value_reg <= mac_acc;
            out_seg_reg   <= seg_reg[SEGOUT_W-1:0];
            if (disorder_reg)
            begin
                out_status_reg <= STS_DISORDER;
            end
            else if (mac_sat)
            begin
                out_status_reg <= STS_SATURATED;
            end
            else
            begin
                out_status_reg <= STS_OK;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_seg_reg, out_value_reg};
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KNOT) |-> (seg_reg < segs_reg))
        else $error("segment index beyond segments in use");

    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCMP) |-> (lo_reg < mid_reg) && (mid_reg < hi_reg))
        else $error("binary search probe outside its interval");

    a_horner_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_ADD)
        |-> (k_reg != '0) && (k_reg <= order_reg))
        else $error("Horner step counter out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && m_tvalid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output register full");
`endif

endmodule
